[design/brb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and codes for the byte ring buffer: operation and status
// codes, the item and result structs, and the memory control bundle.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int LEN_W  = 11;
    localparam int BYTE_W = 8;
    localparam int FILL_W = 11;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_PEEK    = 2'd2,
        OP_CONSUME = 2'd3
    } brb_op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ZERO   = 2'd1,
        ST_SHORT  = 2'd2,
        ST_BEYOND = 2'd3
    } brb_status_t;

    typedef struct packed {
        brb_op_t           op;
        logic              run_start;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] wr_byte;
    } brb_in_t;

    typedef struct packed {
        brb_status_t       status;
        logic [BYTE_W-1:0] rd_byte;
        logic [FILL_W-1:0] fill_count;
        logic              run_last;
    } brb_out_t;

    // Result of one item before the read data joins it
    typedef struct packed {
        brb_status_t       status;
        logic [FILL_W-1:0] fill_count;
        logic              run_last;
        logic              rd_hit;
    } brb_res_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } brb_mem_ctl_t;

endpackage

[design/brb_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_store
// Byte memory of the ring: one write port and one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module brb_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                       aclk,
    input  brb_pkg::brb_mem_ctl_t      mem_ctl,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [brb_pkg::BYTE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [brb_pkg::BYTE_W-1:0] rd_data
);
    import brb_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/brb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ctrl
// Pointer and run control: checks run lengths, steps the head, tail and
// peek pointers, keeps the fill count and issues memory accesses.
// ----------------------------------------------------------------------------
module brb_ctrl #(
    parameter int CAPACITY = 1024,
    parameter int PTR_W    = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  brb_pkg::brb_in_t      item,
    output brb_pkg::brb_mem_ctl_t mem_ctl,
    output logic [PTR_W-1:0]      wr_addr,
    output logic [PTR_W-1:0]      rd_addr,
    output brb_pkg::brb_res_t     res
);
    import brb_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int SUM_W = CMP_W + 1;
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);
    localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] peek_reg, peek_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    brb_op_t          run_op_reg, run_op_next;

    logic [CNT_W-1:0] limit;
    logic [SUM_W-1:0] head_sum;
    logic [PTR_W-1:0] peek_src;
    logic             move;
    brb_op_t          move_op;
    brb_status_t      status;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            peek_reg   <= '0;
            count_reg  <= '0;
            remain_reg <= '0;
            run_op_reg <= OP_WRITE;
        end else if (accept) begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            peek_reg   <= peek_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            run_op_reg <= run_op_next;
        end
    end

    always_comb begin
        limit    = (item.op == OP_WRITE) ? CAP_CNT - count_reg : count_reg;
        head_sum = SUM_W'(head_reg) + SUM_W'(item.length);
        if (head_sum >= CAP_SUM) begin
            head_sum = head_sum - CAP_SUM;
        end

        head_next   = head_reg;
        tail_next   = tail_reg;
        peek_next   = peek_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        run_op_next = run_op_reg;
        status      = ST_OK;
        move        = 1'b0;
        move_op     = run_op_reg;
        peek_src    = peek_reg;

        if (item.run_start) begin
            remain_next = '0;
            if (item.length == '0) begin
                status = ST_ZERO;
            end else if (CMP_W'(item.length) > CMP_W'(limit)) begin
                status = ST_SHORT;
            end else if (item.op == OP_CONSUME) begin
                head_next  = PTR_W'(head_sum);
                count_next = count_reg - CNT_W'(item.length);
            end else begin
                move        = 1'b1;
                move_op     = item.op;
                run_op_next = item.op;
                peek_src    = head_reg;
                remain_next = item.length - LEN_W'(1);
            end
        end else if (remain_reg != '0) begin
            move        = 1'b1;
            remain_next = remain_reg - LEN_W'(1);
        end else begin
            status = ST_BEYOND;
        end

        mem_ctl.wr_en = 1'b0;
        mem_ctl.rd_en = 1'b0;
        wr_addr       = tail_reg;
        rd_addr       = head_reg;

        if (move) begin
            unique case (move_op) inside
                OP_WRITE: begin
                    mem_ctl.wr_en = accept;
                    tail_next     = ptr_inc(tail_reg);
                    if (count_reg != CAP_CNT) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_READ: begin
                    mem_ctl.rd_en = accept;
                    head_next     = ptr_inc(head_reg);
                    if (count_reg != '0) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_PEEK, OP_CONSUME: begin
                    // consume never starts a run; its arm only serves peek
                    mem_ctl.rd_en = accept;
                    rd_addr       = peek_src;
                    peek_next     = ptr_inc(peek_src);
                end
                default: begin
                    mem_ctl.rd_en = 1'b0;
                end
            endcase
        end

        res.status     = status;
        res.fill_count = FILL_W'(count_next);
        res.run_last   = (remain_next == '0);
        res.rd_hit     = move && (move_op != OP_WRITE);
    end

endmodule

[design/byte_ring_buffer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_core
// Byte ring buffer with all-or-nothing write, read, peek and consume runs.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side does not stall, and
// returns one result per item in the cycle after the transfer is accepted.
// Every item does at most one access to the byte memory (a write at the
// tail or a read at the head or peek pointer), and the memory read is
// registered. Results wait in an output register, and a new item is taken
// in the same cycle as the waiting result is taken. No clearing pass is
// needed after reset: only bytes already written are ever read.
module byte_ring_buffer_core #(
    parameter int CAPACITY = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  brb_pkg::brb_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output brb_pkg::brb_out_t m_item
);
    import brb_pkg::*;

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic              accept;
    brb_mem_ctl_t      mem_ctl;
    logic [PTR_W-1:0]  wr_addr;
    logic [PTR_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_data;
    brb_res_t          res;
    brb_res_t          res_reg;
    logic              m_valid_reg, m_valid_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    brb_ctrl #(
        .CAPACITY (CAPACITY),
        .PTR_W    (PTR_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_item),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .res     (res)
    );

    brb_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (PTR_W)
    ) u_store (
        .aclk    (aclk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (s_item.wr_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the result while the downstream side stalls
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_item.status     = res_reg.status;
    assign m_item.rd_byte    = res_reg.rd_hit ? rd_data : '0;
    assign m_item.fill_count = res_reg.fill_count;
    assign m_item.run_last   = res_reg.run_last;

endmodule

[bench/byte_ring_buffer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_core_tb
// Self-checking bench for the byte ring buffer core. A queue of byte items
// (directed corner cases, then random runs with interruptions and noise)
// feeds a valid/ready driver. A ring predictor works out each item's status,
// byte, fill count and run end, and a monitor checks every result transfer
// against the oldest expectation.
// ----------------------------------------------------------------------------
module byte_ring_buffer_core_tb;

    import brb_pkg::*;

    localparam int CAP         = 1024;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PRINT_LIMIT = 60;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    brb_in_t  s_item  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    brb_out_t m_item;

    byte_ring_buffer_core #(
        .CAPACITY (CAP)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Items waiting to be driven, results of items not yet accepted, and
    // results of accepted items still to arrive
    brb_in_t  item_queue[$];
    brb_out_t planned_results[$];
    brb_out_t pending_results[$];

    int unsigned mismatch_count = 0;
    int unsigned items_built    = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_gap       = 0;
    int unsigned recv_gap       = 0;
    bit          quiet          = 1'b0;

    // Ring predictor state
    logic [7:0]  ring_mem [CAP];
    int unsigned head_ptr   = 0;
    int unsigned tail_ptr   = 0;
    int unsigned peek_ptr   = 0;
    int unsigned fill_level = 0;
    int unsigned run_left   = 0;
    bit          run_open   = 1'b0;
    brb_op_t     run_kind   = OP_WRITE;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Move one byte of the open run; returns the byte read or peeked
    function automatic logic [7:0] move_one(logic [7:0] wb);
        logic [7:0] got;
        got = '0;
        case (run_kind)
            OP_WRITE: begin
                ring_mem[tail_ptr] = wb;
                tail_ptr = (tail_ptr + 1) % CAP;
                if (fill_level < CAP) fill_level++;
            end
            OP_READ: begin
                got = ring_mem[head_ptr];
                head_ptr = (head_ptr + 1) % CAP;
                if (fill_level > 0) fill_level--;
            end
            default: begin
                got = ring_mem[peek_ptr];
                peek_ptr = (peek_ptr + 1) % CAP;
            end
        endcase
        return got;
    endfunction

    function automatic brb_out_t predict_result(brb_in_t it);
        brb_out_t    r;
        int unsigned room;
        r.status  = ST_OK;
        r.rd_byte = '0;
        if (it.run_start) begin
            room     = (it.op == OP_WRITE) ? CAP - fill_level : fill_level;
            run_open = 1'b0;
            run_left = 0;
            if (it.length == 0) begin
                r.status = ST_ZERO;
            end else if (it.length > room) begin
                r.status = ST_SHORT;
            end else if (it.op == OP_CONSUME) begin
                head_ptr   = (head_ptr + it.length) % CAP;
                fill_level = fill_level - it.length;
            end else begin
                run_kind = it.op;
                if (it.op == OP_PEEK) peek_ptr = head_ptr;
                r.rd_byte = move_one(it.wr_byte);
                run_left  = it.length - 1;
                run_open  = (run_left > 0);
            end
        end else if (run_open && run_left > 0) begin
            r.rd_byte = move_one(it.wr_byte);
            run_left--;
            if (run_left == 0) run_open = 1'b0;
        end else begin
            r.status = ST_BEYOND;
            run_open = 1'b0;
            run_left = 0;
        end
        r.fill_count = FILL_W'(fill_level);
        r.run_last   = !run_open;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic push_item(input brb_op_t op, input bit start, input int len, input int wb);
        brb_in_t it;
        it.op        = op;
        it.run_start = start;
        it.length    = LEN_W'(len);
        it.wr_byte   = BYTE_W'(wb);
        planned_results.push_back(predict_result(it));
        item_queue.push_back(it);
        items_built++;
    endtask

    // Start a run of len bytes and send n items of it; continuation items
    // carry junk op and length, which the block must ignore
    task automatic send_run(input brb_op_t op, input int len, input int n);
        push_item(op, 1'b1, len, $urandom_range(0, 255));
        for (int k = 1; k < n; k++) begin
            push_item(brb_op_t'($urandom_range(0, 3)), 1'b0, $urandom_range(0, 2047),
                      $urandom_range(0, 255));
        end
    endtask

    task automatic wait_drained();
        while (item_queue.size() != 0 || planned_results.size() != 0 ||
               pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic random_traffic(input int n);
        int unsigned first;
        int unsigned room;
        int          len;
        int          count;
        int          pick;
        brb_op_t     op;
        first = items_built;
        while (items_built - first < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // keep the fill level moving between empty and full
                if (fill_level < 64)
                    op = ($urandom_range(0, 3) != 0) ? OP_WRITE : brb_op_t'($urandom_range(1, 2));
                else if (fill_level > 960)
                    op = brb_op_t'($urandom_range(1, 2));
                else
                    op = brb_op_t'($urandom_range(0, 2));
                room = (op == OP_WRITE) ? CAP - fill_level : fill_level;
                pick = $urandom_range(0, 39);
                if (room == 0 || pick < 2) begin
                    push_item(op, 1'b1, $urandom_range(room + 1, 2047), $urandom_range(0, 255));
                end else begin
                    if (pick == 2)
                        len = $urandom_range(1, room);
                    else
                        len = $urandom_range(1, (room < 24) ? room : 24);
                    count = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : len;
                    send_run(op, len, count);
                end
                if ($urandom_range(0, 9) == 0)
                    push_item(brb_op_t'($urandom_range(0, 3)), 1'b0, $urandom_range(0, 2047),
                              $urandom_range(0, 255));
            end else if (pick < 75) begin
                push_item(OP_CONSUME, 1'b1, $urandom_range(0, fill_level + 2),
                          $urandom_range(0, 255));
            end else begin
                push_item(brb_op_t'($urandom_range(0, 3)), 1'(($urandom_range(0, 1))),
                          $urandom_range(0, 2047), $urandom_range(0, 255));
            end
        end
    endtask

    // Driver: hold the item until its transfer, then maybe idle for a burst
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) pending_results.push_back(planned_results.pop_front());
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (item_queue.size() != 0) begin
                    s_item  <= item_queue.pop_front();
                    s_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 17);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer, and stall the result side at random
    always @(posedge aclk) begin
        brb_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("result transfer with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (m_item.status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                m_item.status, want.status));
                    if (m_item.rd_byte !== want.rd_byte)
                        flag_mismatch($sformatf("rd_byte %02h, expected %02h",
                                                m_item.rd_byte, want.rd_byte));
                    if (m_item.fill_count !== want.fill_count)
                        flag_mismatch($sformatf("fill_count %0d, expected %0d",
                                                m_item.fill_count, want.fill_count));
                    if (m_item.run_last !== want.run_last)
                        flag_mismatch($sformatf("run_last %0b, expected %0b",
                                                m_item.run_last, want.run_last));
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 11) == 0) recv_gap <= $urandom_range(1, 17);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("byte_ring_buffer_core test failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Refusals on an empty buffer and a stray continuation
        push_item(OP_WRITE, 1'b1, 0, 8'h3C);
        push_item(OP_READ, 1'b1, 1, 8'h00);
        push_item(OP_PEEK, 1'b1, 2047, 8'hFF);
        push_item(OP_CONSUME, 1'b1, 1, 8'h00);
        push_item(OP_WRITE, 1'b0, 2047, 8'hFF);
        // Byte extremes, then continuation after the run has ended
        push_item(OP_WRITE, 1'b1, 4, 8'h00);
        push_item(OP_READ, 1'b0, 0, 8'hFF);
        push_item(OP_CONSUME, 1'b0, 2047, 8'hA5);
        push_item(OP_PEEK, 1'b0, 1, 8'h5A);
        push_item(OP_READ, 1'b0, 5, 8'h11);
        push_item(OP_WRITE, 1'b1, 2047, 8'h22);
        send_run(OP_PEEK, 3, 3);
        // Interrupt a peek with a read: the head must not have moved
        send_run(OP_PEEK, 4, 2);
        send_run(OP_READ, 2, 2);
        push_item(OP_PEEK, 1'b0, 0, 8'h00);
        push_item(OP_CONSUME, 1'b1, 3, 8'h00);
        push_item(OP_CONSUME, 1'b1, 0, 8'h00);
        push_item(OP_CONSUME, 1'b1, 1, 8'h00);
        push_item(OP_WRITE, 1'b0, 1, 8'h77);
        send_run(OP_WRITE, 3, 1);
        send_run(OP_PEEK, 2, 2);
        wait_drained();

        random_traffic(720);
        wait_drained();

        // Closing stretch at full rate on both sides
        quiet = 1'b1;
        random_traffic(150);
        wait_drained();
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("byte_ring_buffer_core test passed");
        end else begin
            $display("byte_ring_buffer_core test failed");
        end
        $finish;
    end

endmodule
